// ===== rtl/mrc_pkg.sv =====
package mrc_pkg;

	localparam int INPUT_LANES  = 4;
	localparam int OUTPUT_LANES = 2;
	localparam int RATIO        = INPUT_LANES / OUTPUT_LANES;
	localparam int TAG_ENTRIES  = 8;
	localparam int TAG_BITS     = $clog2(TAG_ENTRIES);
	localparam int ADDR_BITS    = 32;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

	typedef logic [QPTR_BITS-1:0] qptr_t;
	typedef logic [QPTR_BITS:0]   qcnt_t;

	localparam logic [1:0] KIND_RSP   = 2'd0;
	localparam logic [1:0] KIND_MEM   = 2'd1;
	localparam logic [1:0] KIND_STALL = 2'd2;

	localparam logic CMD_RSP = 1'b0;
	localparam logic CMD_REQ = 1'b1;

	localparam logic [3:0] LINE_LOG2_RESET = 4'd6;

	typedef struct packed {
		logic                  cmd;
		logic [3:0]            lane_mask;
		logic                  is_write;
		logic [ADDR_BITS-1:0]  addr_0;
		logic [ADDR_BITS-1:0]  addr_1;
		logic [ADDR_BITS-1:0]  addr_2;
		logic [ADDR_BITS-1:0]  addr_3;
		logic [7:0]            tag;
		logic [7:0]            core_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [3:0]            used_lanes;
		logic                  out_write;
		logic [ADDR_BITS-1:0]  mem_addr_0;
		logic [ADDR_BITS-1:0]  mem_addr_1;
		logic [7:0]            out_tag;
		logic [7:0]            out_core;
		logic                  request_done;
	} out_item_t;

	// Front-end classified entry: aligned addresses and per-lane match info.
	typedef struct packed {
		logic                 cmd;
		logic [3:0]           active;
		logic                 is_write;
		logic [ADDR_BITS-1:0] seed_0;
		logic [ADDR_BITS-1:0] seed_1;
		logic                 same_01;
		logic                 same_23;
		logic [7:0]           tag;
		logic [7:0]           core_id;
	} cls_t;

endpackage

// ===== rtl/mrc_if.sv =====
interface mrc_in_if;
	logic               valid;
	logic               ready;
	mrc_pkg::in_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface mrc_out_if;
	logic               valid;
	logic               ready;
	mrc_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mrc_front.sv =====
module mrc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [3:0]       line_log2,
	input  logic             in_valid,
	output logic             in_ready,
	input  mrc_pkg::in_item_t in_item,
	output logic             q_valid,
	input  logic             q_pop,
	output mrc_pkg::cls_t    q_head
);
	mrc_pkg::cls_t entry_q [mrc_pkg::QUEUE_DEPTH];
	mrc_pkg::qptr_t wr_ptr_q, rd_ptr_q;
	mrc_pkg::qcnt_t count_q;
	logic [mrc_pkg::ADDR_BITS-1:0] lmask;
	logic [mrc_pkg::ADDR_BITS-1:0] a0, a1, a2, a3;
	mrc_pkg::cls_t cls;
	logic push;

	assign lmask = ~((mrc_pkg::ADDR_BITS'(1) << line_log2) - mrc_pkg::ADDR_BITS'(1));
	assign a0 = in_item.addr_0 & lmask;
	assign a1 = in_item.addr_1 & lmask;
	assign a2 = in_item.addr_2 & lmask;
	assign a3 = in_item.addr_3 & lmask;

	// Even lanes seed their group; odd-lane addresses travel beside the queue.
	always_comb begin
		cls.cmd      = in_item.cmd;
		cls.active   = in_item.lane_mask;
		cls.is_write = in_item.is_write;
		cls.seed_0   = a0;
		cls.seed_1   = a2;
		cls.same_01  = (a0 == a1);
		cls.same_23  = (a2 == a3);
		cls.tag      = in_item.tag;
		cls.core_id  = in_item.core_id;
	end

	assign in_ready = (count_q != mrc_pkg::qcnt_t'(mrc_pkg::QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + mrc_pkg::qcnt_t'(push) - mrc_pkg::qcnt_t'(q_pop);
		end
	end
endmodule

// ===== rtl/mrc_back.sv =====
module mrc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  mrc_pkg::cls_t      q_head,
	input  logic [mrc_pkg::ADDR_BITS-1:0] odd_addr_1,
	input  logic [mrc_pkg::ADDR_BITS-1:0] odd_addr_3,
	output logic               out_valid,
	input  logic               out_ready,
	output mrc_pkg::out_item_t out_item
);
	localparam int TB = mrc_pkg::TAG_BITS;
	logic [3:0] sent_q;
	logic [mrc_pkg::TAG_ENTRIES-1:0] tag_valid_q;
	logic [3:0] tag_mask_q [mrc_pkg::TAG_ENTRIES];
	logic [7:0] tag_req_q  [mrc_pkg::TAG_ENTRIES];
	logic       ovalid_q;
	mrc_pkg::out_item_t res;
	mrc_pkg::out_item_t obuf_q;
	logic [3:0] act, unsent, cur, rsp, new_sent, left;
	logic [TB-1:0] free_tag, rtag;
	logic       any_free, tag_ok, go;
	logic       wr_tag, clr_tag, upd_tag, set_sent, clr_sent;

	assign go    = q_valid && (!ovalid_q || out_ready);
	assign q_pop = go;
	assign act    = q_head.active;
	assign unsent = act & ~sent_q;
	assign rtag   = q_head.tag[TB-1:0];
	assign tag_ok = (q_head.tag < 8'(mrc_pkg::TAG_ENTRIES)) && tag_valid_q[rtag];

	always_comb begin
		free_tag = '0;
		any_free = 1'b0;
		for (int k = mrc_pkg::TAG_ENTRIES - 1; k >= 0; k--) begin
			if (!tag_valid_q[k]) begin
				free_tag = TB'(k);
				any_free = 1'b1;
			end
		end
	end

	always_comb begin
		res = '0;
		res.out_core = q_head.core_id;
		cur = '0;
		rsp = '0;
		new_sent = sent_q;
		left = '0;
		wr_tag = 1'b0; clr_tag = 1'b0; upd_tag = 1'b0;
		set_sent = 1'b0; clr_sent = 1'b0;
		if (q_head.cmd == mrc_pkg::CMD_RSP) begin
			res.kind = mrc_pkg::KIND_RSP;
			if (tag_ok) begin
				if (q_head.active[0]) rsp[1:0] = tag_mask_q[rtag][1:0];
				if (q_head.active[1]) rsp[3:2] = tag_mask_q[rtag][3:2];
				left = tag_mask_q[rtag] & ~rsp;
				res.used_lanes = rsp;
				res.out_tag  = tag_req_q[rtag];
				upd_tag = 1'b1;
				clr_tag = (left == 4'd0);
			end
		end else if (!any_free) begin
			res.kind = mrc_pkg::KIND_STALL;
		end else begin
			res.kind = mrc_pkg::KIND_MEM;
			res.out_write = q_head.is_write;
			if (unsent[0]) begin
				cur[0] = 1'b1;
				cur[1] = unsent[1] && q_head.same_01;
				res.used_lanes[0] = 1'b1;
				res.mem_addr_0 = q_head.seed_0;
			end else if (unsent[1]) begin
				cur[1] = 1'b1;
				res.used_lanes[0] = 1'b1;
				res.mem_addr_0 = odd_addr_1;
			end
			if (unsent[2]) begin
				cur[2] = 1'b1;
				cur[3] = unsent[3] && q_head.same_23;
				res.used_lanes[1] = 1'b1;
				res.mem_addr_1 = q_head.seed_1;
			end else if (unsent[3]) begin
				cur[3] = 1'b1;
				res.used_lanes[1] = 1'b1;
				res.mem_addr_1 = odd_addr_3;
			end
			if (cur != 4'd0 && !q_head.is_write) begin
				wr_tag = 1'b1;
				res.out_tag = 8'(free_tag);
			end
			new_sent = sent_q | cur;
			set_sent = 1'b1;
			if ((new_sent & act) == act) begin
				res.request_done = 1'b1;
				clr_sent = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && wr_tag) begin
			tag_mask_q[free_tag] <= cur;
			tag_req_q[free_tag]  <= q_head.tag;
		end else if (go && upd_tag) begin
			tag_mask_q[rtag] <= left;
		end
		if (go) obuf_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			tag_valid_q <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (go) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (go && wr_tag) tag_valid_q[free_tag] <= 1'b1;
			if (go && clr_tag) tag_valid_q[rtag] <= 1'b0;
			if (go && set_sent) sent_q <= clr_sent ? 4'd0 : new_sent;
		end
	end

	assign out_valid = ovalid_q;
	assign out_item  = obuf_q;
endmodule

// ===== rtl/memory_request_coalescer.sv =====
// Channel | Dir | Payload                                  | Accepted when
// req_in  | in  | cmd, lane_mask, is_write, addr_0..3, tag, | valid && ready
//         |     | core_id                                   |
// rsp_out | out | kind, used_lanes, out_write, mem_addr_0..1,| valid && ready
//         |     | out_tag, out_core, request_done           |
// cfg     | in  | cfg_wdata[3:0] = line_bytes_log2           | cfg_we
// A request accepted on req_in is aligned and compared into a two-entry queue;
// the back stage pops it, allocates tags and loads the output register, which
// offers its result, and one request per cycle is sustained while the sink
// keeps ready high.
// Reset (arst_n low) frees every tag, clears the sent-lane mask and the queue.
// A stalled sink holds the output register; two more requests queue behind it
// before req_in.ready drops.
module memory_request_coalescer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	mrc_in_if.sink     req_in,
	mrc_out_if.source  rsp_out
);
	logic [3:0] line_log2_q;
	logic       q_valid, q_pop;
	mrc_pkg::cls_t q_head;
	// Odd lanes' own aligned addresses, kept beside the queue for the case
	// where the even lane of a group is inactive or was already sent.
	logic [mrc_pkg::ADDR_BITS-1:0] odd1_q [mrc_pkg::QUEUE_DEPTH];
	logic [mrc_pkg::ADDR_BITS-1:0] odd3_q [mrc_pkg::QUEUE_DEPTH];
	mrc_pkg::qptr_t owr_q, ord_q;
	logic [mrc_pkg::ADDR_BITS-1:0] lmask;

	// Hold the line-size register; the user must write it only while idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_log2_q <= mrc_pkg::LINE_LOG2_RESET;
		end else if (cfg_we) begin
			line_log2_q <= cfg_wdata;
		end
	end

	assign lmask = ~((mrc_pkg::ADDR_BITS'(1) << line_log2_q) - mrc_pkg::ADDR_BITS'(1));

	// Advance side pointers in lockstep with the front queue.
	always_ff @(posedge clk) begin
		if (req_in.valid && req_in.ready) begin
			odd1_q[owr_q] <= req_in.payload.addr_1 & lmask;
			odd3_q[owr_q] <= req_in.payload.addr_3 & lmask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
		end else begin
			if (req_in.valid && req_in.ready) owr_q <= owr_q + 1'b1;
			if (q_pop) ord_q <= ord_q + 1'b1;
		end
	end

	mrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_log2 (line_log2_q),
		.in_valid  (req_in.valid),
		.in_ready  (req_in.ready),
		.in_item   (req_in.payload),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head)
	);

	mrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_head     (q_head),
		.odd_addr_1 (odd1_q[ord_q]),
		.odd_addr_3 (odd3_q[ord_q]),
		.out_valid  (rsp_out.valid),
		.out_ready  (rsp_out.ready),
		.out_item   (rsp_out.payload)
	);
endmodule

// ===== rtl/mrc_checker.sv =====
module mrc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input mrc_pkg::out_item_t out_item
);
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.kind == mrc_pkg::KIND_RSP ||
		out_item.kind == mrc_pkg::KIND_MEM || out_item.kind == mrc_pkg::KIND_STALL))
		else $error("illegal result kind");
	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == mrc_pkg::KIND_STALL |->
		out_item.used_lanes == 4'd0 && !out_item.request_done)
		else $error("stall result carries lanes");
	a_rsp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == mrc_pkg::KIND_RSP |->
		!out_item.out_write && !out_item.request_done)
		else $error("response carries request fields");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");
endmodule

bind memory_request_coalescer mrc_checker u_mrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp_out.valid),
	.out_ready (rsp_out.ready),
	.out_item  (rsp_out.payload)
);
